// ===== rtl/tli_pkg.sv =====
// tli_pkg: shared constants and types of the table linear interpolation block
`timescale 1ns / 1ps

package tli_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);

   localparam int DATA_W     = 16;
   localparam int COUNT_W    = 5;
   localparam int INDEX_W    = 4;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   // radix-2 divider: one quotient bit per step
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // operation codes carried in tuser
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TOP,
      ST_FIRST,
      ST_WALK,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/table_linear_interpolation.sv =====
// table_linear_interpolation: point table with clamped piecewise linear lookup
`timescale 1ns / 1ps

// channel  dir  beat contents (lowest bits first)
// req_     in   tuser: operation; tdata: point_index, axis_value, table_value, query_x
// rsp_     out  tdata: result_y
// csr_     in   write strobe and data of point_count
//
// a write beat gives no result; the next beat can follow at once
// a lookup at or above the last point or at or below the first takes that point's value;
//   otherwise it walks the bins, reading one table entry per cycle (up to 15 reads), and
//   on finding its bin runs a multiply step, a set-up step, a 16-step radix-2 divider and
//   a saturation step; the next beat can be taken in the cycle in which the result shows
// reset is synchronous; point_count returns to 16, the table itself is not cleared
// a held result in the output register does not stop new beats; only a finished lookup
//   waits for that register to free up

module table_linear_interpolation (
   input  logic                               clock,
   input  logic                               reset,
   // operation
   input  logic                               req_tuser,
   // point_index [3:0], axis_value [19:4], table_value [35:20], query_x [51:36], zero pad
   input  logic [tli_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // result_y [15:0]
   output logic [tli_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_wr_en,
   input  logic [tli_pkg::COUNT_W-1:0]        csr_wr_data
);

   localparam int IW = tli_pkg::IDX_W;
   localparam int DW = tli_pkg::DATA_W;

   // request fields
   logic [tli_pkg::INDEX_W-1:0] req_index;
   logic signed [DW-1:0]        req_axis;
   logic signed [DW-1:0]        req_value;
   logic signed [DW-1:0]        req_x;
   logic                        req_fire;
   logic                        wr_fire;
   logic                        lookup_fire;
   logic                        wr_in_range;

   assign req_index = req_tdata[3:0];
   assign req_axis  = req_tdata[19:4];
   assign req_value = req_tdata[35:20];
   assign req_x     = req_tdata[51:36];

   assign req_fire    = req_tvalid && req_tready;
   assign wr_fire     = req_fire && (req_tuser == tli_pkg::OP_WRITE);
   assign lookup_fire = req_fire && (req_tuser == tli_pkg::OP_LOOKUP);
   assign wr_in_range = (32'(req_index) < tli_pkg::MAX_POINTS);

   // point table: value in the upper half, axis in the lower half
   logic [2*DW-1:0] table_mem [tli_pkg::MAX_POINTS];
   logic [2*DW-1:0] rd_data_ff;
   logic [IW-1:0]   rd_addr;
   logic signed [DW-1:0] rd_axis;
   logic signed [DW-1:0] rd_value;

   assign rd_axis  = rd_data_ff[DW-1:0];
   assign rd_value = rd_data_ff[2*DW-1:DW];

   always_ff @(posedge clock) begin
      if (wr_fire && wr_in_range) begin
         table_mem[IW'(req_index)] <= {req_value, req_axis};
      end
   end

   // writes are only taken while idle, so a lookup never reads an entry mid-update
   always_ff @(posedge clock) begin
      rd_data_ff <= table_mem[rd_addr];
   end

   // configuration
   logic [tli_pkg::COUNT_W-1:0] point_count_ff;
   logic [IW-1:0]               top_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= tli_pkg::COUNT_RESET;
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   // index of the last point in use, count clamped to one..MAX_POINTS
   always_comb begin
      if (point_count_ff == '0) begin
         top_idx = '0;
      end else if (32'(point_count_ff) > tli_pkg::MAX_POINTS) begin
         top_idx = IW'(tli_pkg::MAX_POINTS - 1);
      end else begin
         top_idx = IW'(point_count_ff - tli_pkg::COUNT_W'(1));
      end
   end

   // lookup state
   tli_pkg::state_type state_ff;
   tli_pkg::state_type state_in;

   logic signed [DW-1:0]   x_ff;
   logic [IW-1:0]          idx_ff;
   logic signed [DW-1:0]   hi_axis_ff;     // upper end of the bin
   logic signed [DW-1:0]   hi_value_ff;
   logic signed [DW-1:0]   lo_axis_ff;     // lower end of the bin
   logic signed [DW-1:0]   lo_value_ff;
   logic signed [2*DW+1:0] prod_ff;
   logic [DW-1:0]          width_ff;
   logic                   neg_ff;
   logic [DW-1:0]          rem_ff;
   logic [DW-1:0]          quo_ff;
   logic [tli_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic signed [DW-1:0]   res_ff;
   logic                   rsp_valid_ff;
   logic [DW-1:0]          rsp_data_ff;

   logic x_ge, x_le, x_gt, x_eq;
   logic out_free;
   logic div_last;

   assign x_ge     = (x_ff >= rd_axis);
   assign x_le     = (x_ff <= rd_axis);
   assign x_gt     = (x_ff > rd_axis);
   assign x_eq     = (x_ff == rd_axis);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign div_last = (cnt_ff == tli_pkg::DIV_CNT_W'(tli_pkg::DIV_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tli_pkg::ST_IDLE: begin
            if (lookup_fire) state_in = tli_pkg::ST_TOP;
         end
         tli_pkg::ST_TOP: begin
            if (x_ge) state_in = tli_pkg::ST_DONE;
            else      state_in = tli_pkg::ST_FIRST;
         end
         tli_pkg::ST_FIRST: begin
            if (x_le) state_in = tli_pkg::ST_DONE;
            else      state_in = tli_pkg::ST_WALK;
         end
         tli_pkg::ST_WALK: begin
            if (x_gt)                  state_in = tli_pkg::ST_MUL;
            else if (idx_ff == '0 || x_eq) state_in = tli_pkg::ST_DONE;
         end
         tli_pkg::ST_MUL:  state_in = tli_pkg::ST_PREP;
         tli_pkg::ST_PREP: state_in = tli_pkg::ST_DIV;
         tli_pkg::ST_DIV: begin
            if (div_last) state_in = tli_pkg::ST_FIN;
         end
         tli_pkg::ST_FIN:  state_in = tli_pkg::ST_DONE;
         tli_pkg::ST_DONE: begin
            if (out_free) state_in = tli_pkg::ST_IDLE;
         end
         default: state_in = tli_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_tready = 1'b0;
      rd_addr    = idx_ff;
      case (state_ff)
         tli_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            rd_addr    = top_idx;
         end
         tli_pkg::ST_TOP:   rd_addr = '0;
         tli_pkg::ST_FIRST: rd_addr = idx_ff - IW'(1);
         tli_pkg::ST_WALK:  rd_addr = idx_ff - IW'(1);
         default:           rd_addr = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tli_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   logic signed [DW:0]     dx;
   logic signed [DW:0]     dy;
   logic signed [DW:0]     bin_width;
   logic [2*DW+1:0]        prod_mag;
   logic [DW:0]            trial_shift;
   logic [DW+1:0]          trial_diff;
   logic signed [DW:0]     quo_signed;
   logic signed [DW+1:0]   interp_sum;

   assign dx          = {x_ff[DW-1], x_ff} - {lo_axis_ff[DW-1], lo_axis_ff};
   assign dy          = {hi_value_ff[DW-1], hi_value_ff} - {lo_value_ff[DW-1], lo_value_ff};
   assign bin_width   = {hi_axis_ff[DW-1], hi_axis_ff} - {lo_axis_ff[DW-1], lo_axis_ff};
   assign prod_mag    = prod_ff[2*DW+1] ? (2*DW+2)'(-prod_ff) : prod_ff;
   assign trial_shift = {rem_ff, quo_ff[DW-1]};
   assign trial_diff  = {1'b0, trial_shift} - {2'b00, width_ff};
   assign quo_signed  = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign interp_sum  = {{2{lo_value_ff[DW-1]}}, lo_value_ff}
                      + {quo_signed[DW], quo_signed};

   always_ff @(posedge clock) begin
      case (state_ff)
         tli_pkg::ST_IDLE: begin
            x_ff   <= req_x;
            idx_ff <= top_idx;
         end
         tli_pkg::ST_TOP: begin
            // at or above the last point: clamp to its value
            res_ff      <= rd_value;
            hi_axis_ff  <= rd_axis;
            hi_value_ff <= rd_value;
         end
         tli_pkg::ST_FIRST: begin
            // at or below the first point: clamp to its value
            res_ff <= rd_value;
            idx_ff <= idx_ff - IW'(1);
         end
         tli_pkg::ST_WALK: begin
            res_ff      <= rd_value;
            lo_axis_ff  <= rd_axis;
            lo_value_ff <= rd_value;
            if (!x_gt) begin
               hi_axis_ff  <= rd_axis;
               hi_value_ff <= rd_value;
               idx_ff      <= idx_ff - IW'(1);
            end
         end
         tli_pkg::ST_MUL: begin
            prod_ff  <= dx * dy;
            width_ff <= DW'(bin_width);
         end
         tli_pkg::ST_PREP: begin
            neg_ff <= prod_ff[2*DW+1];
            rem_ff <= prod_mag[2*DW-1:DW];
            quo_ff <= prod_mag[DW-1:0];
            cnt_ff <= '0;
         end
         tli_pkg::ST_DIV: begin
            rem_ff <= trial_diff[DW+1] ? trial_shift[DW-1:0] : trial_diff[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], !trial_diff[DW+1]};
            cnt_ff <= cnt_ff + tli_pkg::DIV_CNT_W'(1);
         end
         tli_pkg::ST_FIN: begin
            if (interp_sum > 18'sd32767) begin
               res_ff <= 16'sh7fff;
            end else if (interp_sum < -18'sd32768) begin
               res_ff <= 16'sh8000;
            end else begin
               res_ff <= DW'(interp_sum);
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == tli_pkg::ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tli_pkg::ST_DONE && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_write_no_work: assert property (@(posedge clock) disable iff (reset)
      wr_fire |=> state_ff == tli_pkg::ST_IDLE)
      else $error("write beat started a lookup");

   a_lookup_starts: assert property (@(posedge clock) disable iff (reset)
      lookup_fire |=> state_ff == tli_pkg::ST_TOP)
      else $error("lookup beat did not start the table walk");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tli_pkg::ST_DIV && div_last) |=> state_ff == tli_pkg::ST_FIN)
      else $error("divider overran its step count");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tli_pkg::ST_DONE && rsp_valid_ff && !rsp_tready)
      |=> state_ff == tli_pkg::ST_DONE && rsp_valid_ff)
      else $error("result dropped while output register was full");

endmodule
